[src/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LSPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LSPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LSPS_ASSERT(lbl, clk, rst_n, prop)
`define LSPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/lsps_pkg.sv]
package lsps_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_APPEND = 3'd2,
    OP_COMMIT = 3'd3,
    OP_RUN    = 3'd4,
    OP_STOP   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    K_SET_CURRENT = 3'd0,
    K_LOAD_ON     = 3'd1,
    K_LOAD_OFF    = 3'd2,
    K_DELAY       = 3'd3,
    K_REPEAT      = 3'd4,
    K_CALL        = 3'd5,
    K_NOP         = 3'd6
  } step_kind_e;

  typedef enum logic [2:0] {
    F_NONE           = 3'd0,
    F_RUN_INVALID    = 3'd1,
    F_CALL_INVALID   = 3'd2,
    F_STACK_OVERFLOW = 3'd3,
    F_BAD_STEP       = 3'd4,
    F_PROGRAM_FULL   = 3'd5
  } fault_e;

  typedef enum logic [0:0] {
    REG_MAX_CURRENT    = 1'b0,
    REG_SETTLE_TIMEOUT = 1'b1
  } reg_e;

  localparam logic [15:0] MaxCurrentReset    = 16'd10000;
  localparam logic [15:0] SettleTimeoutReset = 16'd100;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic        slot_ok;
    logic [2:0]  kind;
    logic        kind_ok;
    logic [31:0] arg;
    logic        settled;
  } item_t;

  typedef struct packed {
    logic [15:0] max_current;
    logic [15:0] settle_timeout;
  } cfg_t;

endpackage

[src/lsps_ifs.sv]
interface lsps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  program_slot;
  logic [2:0]  step_kind;
  logic [31:0] step_argument;
  logic        load_settled;

  modport source (output valid, opcode, program_slot, step_kind, step_argument,
                  load_settled, input ready);
  modport sink   (input valid, opcode, program_slot, step_kind, step_argument,
                  load_settled, output ready);
endinterface

interface lsps_out_if;
  logic        valid;
  logic        ready;
  logic        load_enable;
  logic [15:0] target_current_ma;
  logic        target_written;
  logic        running;
  logic [2:0]  fault;

  modport source (output valid, load_enable, target_current_ma, target_written,
                  running, fault, input ready);
  modport sink   (input valid, load_enable, target_current_ma, target_written,
                  running, fault, output ready);
endinterface

[src/lsps_front.sv]
module lsps_front #(
  parameter int PROGRAM_SLOTS = 11
) (
  lsps_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output lsps_pkg::item_t  push_item_o
);

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

  // classify the beat so the back end only sees ready-made range checks
  always_comb begin
    push_item_o.op      = in_i.opcode;
    push_item_o.slot    = in_i.program_slot;
    push_item_o.slot_ok = ({1'b0, in_i.program_slot} < 5'(PROGRAM_SLOTS));
    push_item_o.kind    = in_i.step_kind;
    push_item_o.kind_ok = (in_i.step_kind <= 3'(lsps_pkg::K_NOP));
    push_item_o.arg     = in_i.step_argument;
    push_item_o.settled = in_i.load_settled;
  end

endmodule

[src/lsps_queue.sv]
module lsps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  lsps_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output lsps_pkg::item_t pop_item_o
);

  lsps_pkg::item_t ent_q [2];
  logic [1:0]      cnt_q, cnt_d;
  logic            wr_q, rd_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= push_item_i;
  end

endmodule

[src/lsps_back.sv]
`include "assert_macros.svh"

module lsps_back #(
  parameter int STEPS_PER_PROGRAM = 32,
  parameter int PROGRAM_SLOTS     = 11,
  parameter int STACK_DEPTH       = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lsps_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  lsps_pkg::item_t q_item_i,
  lsps_out_if.source      out_o
);

  localparam int SW   = (STEPS_PER_PROGRAM > 1) ? $clog2(STEPS_PER_PROGRAM) : 1;
  localparam int STW  = $clog2(STEPS_PER_PROGRAM + 1);
  localparam int SLW  = $clog2(PROGRAM_SLOTS);
  localparam int LVW  = $clog2(STACK_DEPTH + 1);
  localparam int TOPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int AW   = SLW + SW;

  typedef struct packed {
    logic [SLW-1:0] prog;
    logic [STW-1:0] step;
    logic           sub;
    logic [31:0]    step_start;
    logic [31:0]    delay_start;
    logic [31:0]    reps;
  } frame_t;

  function automatic frame_t enter_step(frame_t fr, logic [STW-1:0] s, logic [31:0] t);
    frame_t r;
    r            = fr;
    r.step       = s;
    r.sub        = 1'b0;
    r.step_start = t;
    return r;
  endfunction

  function automatic frame_t new_frame(logic [SLW-1:0] p, logic [31:0] t);
    frame_t r;
    r.prog        = p;
    r.step        = '0;
    r.sub         = 1'b0;
    r.step_start  = t;
    r.delay_start = '0;
    r.reps        = '0;
    return r;
  endfunction

  logic [34:0]     mem [2**AW];
  logic [34:0]     rdata_q;
  lsps_pkg::item_t item_q;
  logic            busy_q, busy_d;

  frame_t          frames_q [STACK_DEPTH];
  frame_t          frames_d [STACK_DEPTH];
  logic [LVW-1:0]  level_q, level_d;
  logic [31:0]     time_q, time_d;
  logic            load_on_q, load_on_d;
  logic [15:0]     setp_q, setp_d;
  logic [STW-1:0]  plen_q [PROGRAM_SLOTS];
  logic [STW-1:0]  plen_d [PROGRAM_SLOTS];
  logic [PROGRAM_SLOTS-1:0] pvalid_q, pvalid_d, perr_q, perr_d;

  logic            ov_q;
  logic            wr_q, run_q;
  logic [2:0]      fault_q;

  logic            pop, exec;
  logic [LVW-1:0]  lvl_m1;
  logic [TOPW-1:0] top_idx, push_idx;
  frame_t          top_f, f;
  logic [AW-1:0]   raddr, waddr;
  logic            mem_we;
  logic            written;
  lsps_pkg::fault_e fault;
  logic [31:0]     tnow, elapsed;
  logic [2:0]      rkind;
  logic [31:0]     rarg;
  logic [SLW-1:0]  sidx;
  logic [STW-1:0]  n;

  assign q_ready_o = !busy_q;
  assign pop       = q_valid_i && !busy_q;
  assign exec      = busy_q && (!ov_q || out_o.ready);

  assign lvl_m1   = level_q - LVW'(1);
  assign top_idx  = lvl_m1[TOPW-1:0];
  assign push_idx = level_q[TOPW-1:0];
  assign top_f    = frames_q[top_idx];
  assign raddr    = {top_f.prog, top_f.step[SW-1:0]};

  assign sidx  = item_q.slot[SLW-1:0];
  assign n     = plen_q[sidx];
  assign waddr = {sidx, n[SW-1:0]};
  assign tnow  = time_q + 32'd1;
  assign rkind = rdata_q[34:32];
  assign rarg  = rdata_q[31:0];
  assign elapsed = tnow - top_f.step_start;

  always_comb begin
    busy_d = busy_q;
    if (pop) begin
      busy_d = 1'b1;
    end else if (exec) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    frames_d  = frames_q;
    level_d   = level_q;
    time_d    = time_q;
    load_on_d = load_on_q;
    setp_d    = setp_q;
    plen_d    = plen_q;
    pvalid_d  = pvalid_q;
    perr_d    = perr_q;
    mem_we    = 1'b0;
    written   = 1'b0;
    fault     = lsps_pkg::F_NONE;
    f         = top_f;
    if (exec) begin
      unique case (item_q.op)
        lsps_pkg::OP_TICK: begin
          time_d = tnow;
          if (level_q != '0) begin
            if (!pvalid_q[top_f.prog]) begin
              level_d   = '0;
              load_on_d = 1'b0;
              fault     = lsps_pkg::F_RUN_INVALID;
            end else if (top_f.step >= plen_q[top_f.prog]) begin
              level_d = lvl_m1;
              if (lvl_m1 == '0) load_on_d = 1'b0;
            end else begin
              case (rkind)
                lsps_pkg::K_SET_CURRENT: begin
                  if (!top_f.sub) begin
                    setp_d  = (|rarg[31:16]) ? 16'hFFFF : rarg[15:0];
                    written = 1'b1;
                    f.sub   = 1'b1;
                  end
                  if (item_q.settled || !load_on_q ||
                      elapsed > {16'd0, cfg_i.settle_timeout}) begin
                    f = enter_step(f, top_f.step + STW'(1), tnow);
                  end
                end
                lsps_pkg::K_LOAD_ON: begin
                  load_on_d = 1'b1;
                  if (item_q.settled || elapsed > {16'd0, cfg_i.settle_timeout}) begin
                    f = enter_step(f, top_f.step + STW'(1), tnow);
                  end
                end
                lsps_pkg::K_LOAD_OFF: begin
                  load_on_d = 1'b0;
                  f = enter_step(f, top_f.step + STW'(1), tnow);
                end
                lsps_pkg::K_DELAY: begin
                  if (!top_f.sub) begin
                    f.delay_start = tnow;
                    f.sub         = 1'b1;
                  end else if ((tnow - top_f.delay_start) >= rarg) begin
                    f = enter_step(f, top_f.step + STW'(1), tnow);
                  end
                end
                lsps_pkg::K_REPEAT: begin
                  if (top_f.reps < rarg) begin
                    f      = enter_step(f, '0, tnow);
                    f.reps = top_f.reps + 32'd1;
                  end else begin
                    f = enter_step(f, top_f.step + STW'(1), tnow);
                  end
                end
                lsps_pkg::K_CALL: begin
                  if (rarg >= 32'(PROGRAM_SLOTS) || !pvalid_q[rarg[SLW-1:0]]) begin
                    level_d   = '0;
                    load_on_d = 1'b0;
                    fault     = lsps_pkg::F_CALL_INVALID;
                  end else begin
                    f = enter_step(f, top_f.step + STW'(1), tnow);
                    if (level_q >= LVW'(STACK_DEPTH)) begin
                      level_d   = '0;
                      load_on_d = 1'b0;
                      fault     = lsps_pkg::F_STACK_OVERFLOW;
                    end else begin
                      frames_d[push_idx] = new_frame(rarg[SLW-1:0], tnow);
                      level_d            = level_q + LVW'(1);
                    end
                  end
                end
                default: begin
                  f = enter_step(f, top_f.step + STW'(1), tnow);
                end
              endcase
              // the caller frame sits below any pushed callee, so no clash
              frames_d[top_idx] = f;
            end
          end
        end
        lsps_pkg::OP_CLEAR: begin
          if (!item_q.slot_ok) begin
            fault = lsps_pkg::F_BAD_STEP;
          end else begin
            level_d        = '0;
            load_on_d      = 1'b0;
            plen_d[sidx]   = '0;
            pvalid_d[sidx] = 1'b0;
            perr_d[sidx]   = 1'b0;
          end
        end
        lsps_pkg::OP_APPEND: begin
          if (!item_q.slot_ok) begin
            fault = lsps_pkg::F_BAD_STEP;
          end else if (!item_q.kind_ok) begin
            perr_d[sidx]   = 1'b1;
            pvalid_d[sidx] = 1'b0;
            fault          = lsps_pkg::F_BAD_STEP;
          end else if (n >= STW'(STEPS_PER_PROGRAM)) begin
            perr_d[sidx]   = 1'b1;
            pvalid_d[sidx] = 1'b0;
            fault          = lsps_pkg::F_PROGRAM_FULL;
          end else if (item_q.kind == 3'(lsps_pkg::K_CALL) &&
                       item_q.arg >= 32'(PROGRAM_SLOTS - 1)) begin
            perr_d[sidx]   = 1'b1;
            pvalid_d[sidx] = 1'b0;
            fault          = lsps_pkg::F_BAD_STEP;
          end else begin
            mem_we       = 1'b1;
            plen_d[sidx] = n + STW'(1);
            if (item_q.kind == 3'(lsps_pkg::K_SET_CURRENT) &&
                item_q.arg > {16'd0, cfg_i.max_current}) begin
              perr_d[sidx]   = 1'b1;
              pvalid_d[sidx] = 1'b0;
              fault          = lsps_pkg::F_BAD_STEP;
            end
          end
        end
        lsps_pkg::OP_COMMIT: begin
          if (!item_q.slot_ok) begin
            fault = lsps_pkg::F_BAD_STEP;
          end else if (perr_q[sidx]) begin
            pvalid_d[sidx] = 1'b0;
            fault          = lsps_pkg::F_BAD_STEP;
          end else begin
            pvalid_d[sidx] = 1'b1;
          end
        end
        lsps_pkg::OP_RUN: begin
          if (!item_q.slot_ok || !pvalid_q[sidx]) begin
            fault = lsps_pkg::F_RUN_INVALID;
          end else begin
            load_on_d            = 1'b0;
            frames_d[TOPW'(0)]   = new_frame(sidx, time_q);
            level_d              = LVW'(1);
          end
        end
        lsps_pkg::OP_STOP: begin
          level_d   = '0;
          load_on_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // step memory: read for the top frame when the beat is taken, written back on append
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= {item_q.kind, item_q.arg};
    if (pop) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pop) item_q <= q_item_i;
    frames_q <= frames_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      level_q   <= '0;
      time_q    <= '0;
      load_on_q <= 1'b0;
      setp_q    <= '0;
      plen_q    <= '{default: '0};
      pvalid_q  <= '0;
      perr_q    <= '0;
      ov_q      <= 1'b0;
      wr_q      <= 1'b0;
      run_q     <= 1'b0;
      fault_q   <= 3'(lsps_pkg::F_NONE);
    end else begin
      busy_q    <= busy_d;
      level_q   <= level_d;
      time_q    <= time_d;
      load_on_q <= load_on_d;
      setp_q    <= setp_d;
      plen_q    <= plen_d;
      pvalid_q  <= pvalid_d;
      perr_q    <= perr_d;
      if (exec) begin
        ov_q    <= 1'b1;
        wr_q    <= written;
        run_q   <= (level_d != '0);
        fault_q <= 3'(fault);
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_o.valid             = ov_q;
  assign out_o.load_enable       = load_on_q;
  assign out_o.target_current_ma = setp_q;
  assign out_o.target_written    = wr_q;
  assign out_o.running           = run_q;
  assign out_o.fault             = fault_q;

  `LSPS_ASSERT(a_level_bound, clk_i, rst_ni, level_q <= LVW'(STACK_DEPTH))
  `LSPS_ASSERT(a_hold_item, clk_i, rst_ni, busy_q && !exec |=> busy_q && $stable(item_q))
  `LSPS_ASSERT(a_written_clean, clk_i, rst_ni, ov_q && wr_q |-> fault_q == 3'(lsps_pkg::F_NONE))

endmodule

[src/load_step_program_sequencer.sv]
// Channel  | Dir | Payload
// in_i     | in  | opcode, program_slot, step_kind, step_argument, load_settled
// out_o    | out | load_enable, target_current_ma, target_written, running, fault
// APB      | in  | max_current_ma at 0x0, settle_timeout_ms at 0x4
//
// Each beat is handled in the back end by a step-memory read for the top stack
// frame, then execution and write-back; no new beat is taken until the current one
// has executed, and execution waits while a result is held in the output register.
// Input beats land in a two-entry queue, so the input side takes up to three more
// beats (two queued, one held in the back end) while a result waits, then stalls.
// Reset clears program lengths, valid and error flags, the stack level and time.
module load_step_program_sequencer #(
  parameter int STEPS_PER_PROGRAM = 32,
  parameter int PROGRAM_SLOTS     = 11,
  parameter int STACK_DEPTH       = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsps_in_if.sink     in_i,
  lsps_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lsps_pkg::cfg_t  cfg_q;
  lsps_pkg::item_t push_item, pop_item;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  lsps_pkg::reg_e  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = lsps_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_current    <= lsps_pkg::MaxCurrentReset;
      cfg_q.settle_timeout <= lsps_pkg::SettleTimeoutReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        lsps_pkg::REG_MAX_CURRENT:    cfg_q.max_current    <= pwdata[15:0];
        lsps_pkg::REG_SETTLE_TIMEOUT: cfg_q.settle_timeout <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lsps_pkg::REG_MAX_CURRENT:    prdata = {16'd0, cfg_q.max_current};
      lsps_pkg::REG_SETTLE_TIMEOUT: prdata = {16'd0, cfg_q.settle_timeout};
      default:                      prdata = '0;
    endcase
  end

  lsps_front #(
    .PROGRAM_SLOTS(PROGRAM_SLOTS)
  ) u_front (
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  lsps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  lsps_back #(
    .STEPS_PER_PROGRAM(STEPS_PER_PROGRAM),
    .PROGRAM_SLOTS    (PROGRAM_SLOTS),
    .STACK_DEPTH      (STACK_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(pop_valid),
    .q_ready_o(pop_ready),
    .q_item_i (pop_item),
    .out_o    (out_o)
  );

endmodule
